@@ rtl/spim_pkg.sv @@
// Shared widths, codes and types for the serpentine piece index mapper.
package spim_pkg;

    // Field and register widths
    localparam int ID_W       = 16;
    localparam int CNT_W      = 9;
    localparam int ACT_W      = 3;
    localparam int OUT_W      = 8;
    localparam int TOTAL_W    = 2 * CNT_W;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // Divider arrangement: quotient bits, bits resolved per stage, stages
    localparam int QW         = CNT_W;
    localparam int STAGE_BITS = 3;
    localparam int DIV_STAGES = QW / STAGE_BITS;

    // Register map, word index
    typedef enum logic [1:0] {
        REG_COLUMN_COUNT = 2'd0,
        REG_ROW_COUNT    = 2'd1,
        REG_XFORM_EN     = 2'd2,
        REG_ACTION       = 2'd3
    } reg_idx_t;

    // Remap action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE      = 3'd0,
        ACT_MIRROR_LR = 3'd1,
        ACT_MIRROR_UD = 3'd2,
        ACT_ROTATE    = 3'd3
    } action_t;

    // Settings handed from the register block to the datapath
    typedef struct packed {
        logic [CNT_W-1:0]   cols;
        logic [CNT_W-1:0]   rows;
        logic               xform_en;
        logic [ACT_W-1:0]   action;
        logic [TOTAL_W-1:0] total;
        logic [CNT_W-1:0]   height;
    } cfg_t;

endpackage

@@ rtl/spim_cfg.sv @@
// APB register block with derived panel size and strip height.
module spim_cfg
    import spim_pkg::*;
#(
    parameter int STRIP_COUNT = 4,
    parameter int MAX_SIDE    = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    // Strip height = rows / STRIP_COUNT by reciprocal multiply (exact below 2**CNT_W)
    localparam int RECIP_SHIFT = 14;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP       = (2 ** RECIP_SHIFT + STRIP_COUNT - 1) / STRIP_COUNT;
    localparam int HEIGHT_RST  = 1 / STRIP_COUNT;

    logic [CNT_W-1:0]         column_count_reg;
    logic [CNT_W-1:0]         row_count_reg;
    logic                     transform_enable_reg;
    logic [ACT_W-1:0]         action_code_reg;
    logic [TOTAL_W-1:0]       total_reg;
    logic [CNT_W-1:0]         height_reg;
    logic                     wr_en;
    logic [CNT_W-1:0]         wdata_sat;
    logic [CNT_W+RECIP_W-1:0] height_prod;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Count writes saturate to the largest side
    assign wdata_sat = (32'(pwdata[CNT_W-1:0]) > MAX_SIDE) ? CNT_W'(MAX_SIDE)
                                                           : pwdata[CNT_W-1:0];

    assign height_prod = CNT_W'(row_count_reg) * RECIP_W'(RECIP);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg     <= CNT_W'(1);
            row_count_reg        <= CNT_W'(1);
            transform_enable_reg <= 1'b0;
            action_code_reg      <= ACT_NONE;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_COLUMN_COUNT: column_count_reg     <= wdata_sat;
                REG_ROW_COUNT:    row_count_reg        <= wdata_sat;
                REG_XFORM_EN:     transform_enable_reg <= pwdata[0];
                REG_ACTION:       action_code_reg      <= pwdata[ACT_W-1:0];
            endcase
        end
    end

    // Derived values, registered from the counts, so they settle in the cycle after a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= TOTAL_W'(1);
            height_reg <= CNT_W'(HEIGHT_RST);
        end
        else
        begin
            total_reg  <= TOTAL_W'(column_count_reg) * TOTAL_W'(row_count_reg);
            height_reg <= height_prod[RECIP_SHIFT +: CNT_W];
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_COLUMN_COUNT: prdata = DATA_W'(column_count_reg);
            REG_ROW_COUNT:    prdata = DATA_W'(row_count_reg);
            REG_XFORM_EN:     prdata = DATA_W'(transform_enable_reg);
            REG_ACTION:       prdata = DATA_W'(action_code_reg);
        endcase
    end

    assign cfg.cols     = column_count_reg;
    assign cfg.rows     = row_count_reg;
    assign cfg.xform_en = transform_enable_reg;
    assign cfg.action   = action_code_reg;
    assign cfg.total    = total_reg;
    assign cfg.height   = height_reg;

endmodule

@@ rtl/spim_div.sv @@
// Pipelined restoring divider, STAGE_BITS quotient bits per stage, with sideband.
module spim_div
    import spim_pkg::*;
#(
    parameter int DW = 16,
    parameter int SW = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DW-1:0]    dividend,
    input  logic [CNT_W-1:0] divisor,
    input  logic [SW-1:0]    in_side,
    output logic             out_valid,
    output logic [QW-1:0]    quot,
    output logic [DW-1:0]    rem,
    output logic [SW-1:0]    out_side
);

    localparam int XW = DW + QW;

    logic [DIV_STAGES-1:0] v_reg;
    logic [DW-1:0]         r_reg    [DIV_STAGES];
    logic [QW-1:0]         q_reg    [DIV_STAGES];
    logic [SW-1:0]         side_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic          v_in;
        logic [DW-1:0] r_in;
        logic [QW-1:0] q_in;
        logic [SW-1:0] side_in;
        logic [XW-1:0] r_work;
        logic [XW-1:0] trial;
        logic [QW-1:0] q_work;

        if (s == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign r_in    = dividend;
            assign q_in    = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = v_reg[s-1];
            assign r_in    = r_reg[s-1];
            assign q_in    = q_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        // Resolve this stage's quotient bits, most significant first
        always_comb
        begin
            r_work = XW'(r_in);
            q_work = q_in;
            trial  = '0;
            for (int j = 0; j < STAGE_BITS; j++)
            begin
                trial = XW'(divisor) << (QW - 1 - s * STAGE_BITS - j);
                if (r_work >= trial)
                begin
                    r_work = r_work - trial;
                    q_work[QW - 1 - s * STAGE_BITS - j] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s]    <= r_work[DW-1:0];
                q_reg[s]    <= q_work;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign quot      = q_reg[DIV_STAGES-1];
    assign rem       = r_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

@@ rtl/serpentine_piece_index_mapper.sv @@
// Top level of the serpentine piece index mapper: range check, dividers, remap, output.
//
// Usage
//   Input channel piece_valid/piece_ready carries piece_number; output channel
//   result_valid/result_ready carries valid_res, column, panel_row, strip and
//   strip_row, one result per input transfer, in order.
//   Settings are written over the APB port while no transfer is in flight; the user ensures this, the block does not.
// Timing
//   From input transfer to result_valid a piece passes one range-check stage,
//   three stages dividing by row_count, one remap stage, three stages dividing
//   by the strip height and the output register. Each divider resolves three
//   quotient bits per stage. Throughput is one transfer per cycle when not stalled.
// Reset and stalls
//   rst_n clears all stage valids and loads column_count = row_count = 1,
//   transform off, action none. When result_ready is low with a result held,
//   the whole pipeline holds and piece_ready falls; nothing is lost or repeated.
//   Out-of-range indices and a zero strip height give valid_res = 0, fields 0.
module serpentine_piece_index_mapper
    import spim_pkg::*;
#(
    parameter int STRIP_COUNT = 4,
    parameter int MAX_SIDE    = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              piece_valid,
    output logic              piece_ready,
    input  logic [ID_W-1:0]   piece_number,
    output logic              result_valid,
    input  logic              result_ready,
    output logic              valid_res,
    output logic [OUT_W-1:0]  column,
    output logic [OUT_W-1:0]  panel_row,
    output logic [OUT_W-1:0]  strip,
    output logic [OUT_W-1:0]  strip_row
);

    // Sideband through the second divider
    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
    } side2_t;

    cfg_t             cfg;
    logic             en;

    logic             a_valid_reg;
    logic             a_ok_reg;
    logic [ID_W-1:0]  a_id_reg;

    logic             d1_valid;
    logic [QW-1:0]    d1_quot;
    logic [ID_W-1:0]  d1_rem;
    logic             d1_ok;

    logic             b_valid_reg;
    logic             b_ok_reg;
    logic [CNT_W-1:0] b_col_reg;
    logic [CNT_W-1:0] b_row_reg;
    logic [CNT_W-1:0] row_dec;
    logic [CNT_W-1:0] b_col_next;
    logic [CNT_W-1:0] b_row_next;
    logic             mirror_col;
    logic             mirror_row;

    side2_t           b_side;
    side2_t           d2_side;
    logic             d2_valid;
    logic [QW-1:0]    d2_quot;
    logic [CNT_W-1:0] d2_rem;

    logic             res_valid_reg;
    logic             valid_res_reg;
    logic [OUT_W-1:0] column_reg;
    logic [OUT_W-1:0] panel_row_reg;
    logic [OUT_W-1:0] strip_reg;
    logic [OUT_W-1:0] strip_row_reg;

    spim_cfg #(
        .STRIP_COUNT (STRIP_COUNT),
        .MAX_SIDE    (MAX_SIDE)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Whole pipeline advances unless a result is held back
    assign en          = !res_valid_reg || result_ready;
    assign piece_ready = en;

    // Stage A: range check on the index before any remap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= piece_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_id_reg <= piece_number;
            a_ok_reg <= (TOTAL_W'(piece_number) < cfg.total) && (cfg.height != '0);
        end
    end

    // Column = index / rows
    spim_div #(
        .DW (ID_W),
        .SW (1)
    ) u_div_rows (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid_reg),
        .dividend  (a_id_reg),
        .divisor   (cfg.rows),
        .in_side   (a_ok_reg),
        .out_valid (d1_valid),
        .quot      (d1_quot),
        .rem       (d1_rem),
        .out_side  (d1_ok)
    );

    // Stage B: serpentine row, then mirror column and/or row
    always_comb
    begin
        row_dec    = d1_quot[0] ? (cfg.rows - CNT_W'(1) - d1_rem[CNT_W-1:0])
                                : d1_rem[CNT_W-1:0];
        mirror_col = 1'b0;
        mirror_row = 1'b0;
        if (cfg.xform_en)
        begin
            case (cfg.action)
                ACT_MIRROR_LR: mirror_col = 1'b1;
                ACT_MIRROR_UD: mirror_row = 1'b1;
                ACT_ROTATE:
                begin
                    mirror_col = 1'b1;
                    mirror_row = 1'b1;
                end
                default:
                begin
                    mirror_col = 1'b0;
                    mirror_row = 1'b0;
                end
            endcase
        end
        b_col_next = mirror_col ? (cfg.cols - CNT_W'(1) - d1_quot) : d1_quot;
        b_row_next = mirror_row ? (cfg.rows - CNT_W'(1) - row_dec) : row_dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_ok_reg  <= d1_ok;
            b_col_reg <= b_col_next;
            b_row_reg <= b_row_next;
        end
    end

    assign b_side.ok  = b_ok_reg;
    assign b_side.col = b_col_reg;
    assign b_side.row = b_row_reg;

    // Strip = panel row / strip height, remainder is the row within the strip
    spim_div #(
        .DW (CNT_W),
        .SW ($bits(side2_t))
    ) u_div_height (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_valid_reg),
        .dividend  (b_row_reg),
        .divisor   (cfg.height),
        .in_side   (b_side),
        .out_valid (d2_valid),
        .quot      (d2_quot),
        .rem       (d2_rem),
        .out_side  (d2_side)
    );

    // Output register, fields forced to zero for a rejected index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            valid_res_reg <= d2_side.ok;
            column_reg    <= d2_side.ok ? d2_side.col[OUT_W-1:0] : '0;
            panel_row_reg <= d2_side.ok ? d2_side.row[OUT_W-1:0] : '0;
            strip_reg     <= d2_side.ok ? d2_quot[OUT_W-1:0] : '0;
            strip_row_reg <= d2_side.ok ? d2_rem[OUT_W-1:0] : '0;
        end
    end

    assign result_valid = res_valid_reg;
    assign valid_res    = valid_res_reg;
    assign column       = column_reg;
    assign panel_row    = panel_row_reg;
    assign strip        = strip_reg;
    assign strip_row    = strip_row_reg;

endmodule

@@ sim/serpentine_piece_index_mapper_test.sv @@
// Self-checking testbench for the serpentine piece index mapper.
module serpentine_piece_index_mapper_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spim_pkg::*;

    localparam int STRIPS     = 4;
    localparam int SIDE_MAX   = 256;
    localparam int SETTLE     = 30;
    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_CAP  = 100;

    // Expected decode of one piece
    typedef struct packed {
        logic             ok;
        logic [OUT_W-1:0] col;
        logic [OUT_W-1:0] prow;
        logic [OUT_W-1:0] strp;
        logic [OUT_W-1:0] srow;
    } placement_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              piece_valid = 1'b0;
    logic              piece_ready;
    logic [ID_W-1:0]   piece_number = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic              valid_res;
    logic [OUT_W-1:0]  column;
    logic [OUT_W-1:0]  panel_row;
    logic [OUT_W-1:0]  strip;
    logic [OUT_W-1:0]  strip_row;

    // Shadow copy of the panel settings
    int unsigned       panel_cols = 1;
    int unsigned       panel_rows = 1;
    logic              remap_on = 1'b0;
    logic [ACT_W-1:0]  remap_action = ACT_NONE;

    placement_t        placement_q[$];
    placement_t        due;
    int unsigned       mismatch_count = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       send_idle_pct = 0;
    int unsigned       stall_pct = 0;

    serpentine_piece_index_mapper #(
        .STRIP_COUNT (STRIPS),
        .MAX_SIDE    (SIDE_MAX)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .piece_valid  (piece_valid),
        .piece_ready  (piece_ready),
        .piece_number (piece_number),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .valid_res    (valid_res),
        .column       (column),
        .panel_row    (panel_row),
        .strip        (strip),
        .strip_row    (strip_row)
    );

    // Clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Serpentine index to column and row
    function automatic void split_index(input int unsigned idx, input int unsigned rows,
                                        output int unsigned col, output int unsigned row);
        col = idx / rows;
        if (col[0])
            row = rows * (col + 1) - 1 - idx;
        else
            row = idx - rows * col;
    endfunction

    // Column and row back to serpentine index
    function automatic int unsigned join_index(input int unsigned col, input int unsigned row,
                                               input int unsigned rows);
        if (col[0])
            return rows * (col + 1) - 1 - row;
        return rows * col + row;
    endfunction

    // Decode of one piece number under the current settings
    function automatic placement_t locate_piece(input logic [ID_W-1:0] num);
        placement_t  res;
        int unsigned height;
        int unsigned idx;
        int unsigned c;
        int unsigned r;
        res    = '0;
        height = panel_rows / STRIPS;
        idx    = 32'(num);
        if (idx >= panel_cols * panel_rows || height == 0)
            return res;
        if (remap_on)
        begin
            split_index(idx, panel_rows, c, r);
            case (remap_action)
                ACT_MIRROR_LR: idx = join_index(panel_cols - 1 - c, r, panel_rows);
                ACT_MIRROR_UD: idx = join_index(c, panel_rows - 1 - r, panel_rows);
                ACT_ROTATE:    idx = join_index(panel_cols - 1 - c, panel_rows - 1 - r,
                                                panel_rows);
                default:       ;
            endcase
        end
        split_index(idx, panel_rows, c, r);
        res.ok   = 1'b1;
        res.col  = OUT_W'(c);
        res.prow = OUT_W'(r);
        res.strp = OUT_W'(r / height);
        res.srow = OUT_W'(r % height);
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Result side: check each transfer, then draw the next ready
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (placement_q.size() == 0)
                flag_mismatch("unexpected result, pending count", 1, 0);
            else
            begin
                due = placement_q.pop_front();
                if (valid_res !== due.ok)
                    flag_mismatch("valid_res", int'(valid_res), int'(due.ok));
                if (column !== due.col)
                    flag_mismatch("column", int'(column), int'(due.col));
                if (panel_row !== due.prow)
                    flag_mismatch("panel_row", int'(panel_row), int'(due.prow));
                if (strip !== due.strp)
                    flag_mismatch("strip", int'(strip), int'(due.strp));
                if (strip_row !== due.srow)
                    flag_mismatch("strip_row", int'(strip_row), int'(due.srow));
            end
        end
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles with no transfer of any kind
    always @(posedge clk)
    begin
        if (!rst_n || (piece_valid && piece_ready) || (result_valid && result_ready)
            || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // One piece transfer, with random idle cycles ahead of it
    task automatic send_piece(input logic [ID_W-1:0] num);
        while ($urandom_range(99) < send_idle_pct)
        begin
            piece_valid <= 1'b0;
            @(posedge clk);
        end
        piece_valid  <= 1'b1;
        piece_number <= num;
        do
            @(posedge clk);
        while (!piece_ready);
        placement_q.push_back(locate_piece(num));
    endtask

    // Hold the sender until every result is back
    task automatic wait_drained();
        piece_valid <= 1'b0;
        while (placement_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // APB write: setup then access, shadow copy updated alongside
    task automatic write_setting(input reg_idx_t which, input logic [DATA_W-1:0] value);
        int unsigned side;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({which, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        side = 32'(value[CNT_W-1:0]);
        if (side > SIDE_MAX)
            side = SIDE_MAX;
        case (which)
            REG_COLUMN_COUNT: panel_cols   = side;
            REG_ROW_COUNT:    panel_rows   = side;
            REG_XFORM_EN:     remap_on     = value[0];
            REG_ACTION:       remap_action = value[ACT_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic apply_panel(input logic [DATA_W-1:0] cols, input logic [DATA_W-1:0] rows,
                               input logic xen, input logic [ACT_W-1:0] act);
        wait_drained();
        write_setting(REG_COLUMN_COUNT, cols);
        write_setting(REG_ROW_COUNT, rows);
        write_setting(REG_XFORM_EN, DATA_W'(xen));
        write_setting(REG_ACTION, DATA_W'(act));
    endtask

    // Count value: mostly ordinary, sometimes an extreme, a saturating or a tiny one
    function automatic logic [DATA_W-1:0] draw_count();
        case ($urandom_range(11))
            0:       return SIDE_MAX;
            1:       return 1;
            2:       return $urandom_range(SIDE_MAX + 1, 511);
            3:       return $urandom_range(0, 3);
            default: return $urandom_range(4, SIDE_MAX);
        endcase
    endfunction

    // Piece number: mostly on the panel, some at the boundary, some anywhere
    function automatic logic [ID_W-1:0] draw_piece();
        int unsigned total;
        int unsigned k;
        total = panel_cols * panel_rows;
        k     = $urandom_range(19);
        if (total == 0 || k < 3)
            return ID_W'($urandom_range(16'hFFFF));
        if (k == 3)
            return ID_W'(total - 1);
        if (k == 4)
            return ID_W'(total);
        return ID_W'($urandom_range(total - 1));
    endfunction

    // Settings straight out of reset: one row, so strip height is zero
    task automatic test_reset_values();
        send_piece(16'h0000);
        send_piece(16'hFFFF);
    endtask

    // Full-size panel, piece numbers at the edges of the field
    task automatic test_field_extremes();
        apply_panel(SIDE_MAX, SIDE_MAX, 1'b0, ACT_NONE);
        send_piece(16'h0000);
        send_piece(16'hFFFF);
        send_piece(16'h00FF);
        send_piece(16'h0100);
        send_piece(16'h7FFF);
    endtask

    // Empty panel, short panel, saturating and masked count writes
    task automatic test_special_counts();
        apply_panel(0, 8, 1'b0, ACT_NONE);
        send_piece(16'h0000);
        apply_panel(4, 3, 1'b0, ACT_NONE);
        send_piece(16'h0000);
        apply_panel(32'h1FF, 300, 1'b1, ACT_ROTATE);
        send_piece(16'h0000);
        send_piece(16'hFFFF);
        apply_panel(4, 32'h200, 1'b0, ACT_NONE);
        send_piece(16'h0001);
    endtask

    // Each action code on a small panel, unused codes included
    task automatic test_every_action();
        for (int a = 0; a < 8; a++)
        begin
            apply_panel(5, 8, 1'b1, ACT_W'(a));
            send_piece(16'd11);
        end
    endtask

    // Random settings and pieces under each idling pattern
    task automatic test_random_traffic();
        int unsigned idle_plan[4][2] = '{'{0, 0}, '{72, 0}, '{0, 72}, '{13, 13}};
        logic [ACT_W-1:0] act;
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = idle_plan[phase][0];
            stall_pct     = idle_plan[phase][1];
            for (int s = 0; s < 3; s++)
            begin
                act = ACT_W'($urandom_range(7));
                if ($urandom_range(3) != 0)
                    act = ACT_W'($urandom_range(1, 3));
                apply_panel(draw_count(), draw_count(), 1'($urandom_range(1)), act);
                for (int n = 0; n < 44; n++)
                begin
                    if (phase == 1 && s == 0 && n == 22)
                        wait_drained();
                    send_piece(draw_piece());
                end
            end
        end
    endtask

    // Sequence
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_field_extremes();
        test_special_counts();
        test_every_action();
        test_random_traffic();
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/spim_pkg.sv
rtl/spim_cfg.sv
rtl/spim_div.sv
rtl/serpentine_piece_index_mapper.sv
sim/serpentine_piece_index_mapper_test.sv
